[hw/rtl/tscs_pkg.sv]
// Shared types and constants for the text screen control stream engine.
// Used by the front decoder, the command queue, the back executor and the top level.
package tscs_pkg;

    localparam int MAX_ROWS_DEF = 50;
    localparam int COLUMNS_DEF  = 80;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h1F;
    localparam logic [7:0] SAFE_ATTR  = 8'h04;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam logic [2:0] CODE_SET_ATTR      = 3'd1;
    localparam logic [2:0] CODE_SET_CURSOR    = 3'd2;
    localparam logic [2:0] CODE_SET_CELL_ATTR = 3'd3;
    localparam logic [2:0] CODE_SET_LINES     = 3'd4;
    localparam logic [2:0] CODE_SCROLL        = 3'd5;
    localparam logic [2:0] CODE_SET_REGION    = 3'd6;
    localparam logic [2:0] CODE_CLEAR         = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_READ    = 3'd1,
        OP_CMD     = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_NEWLINE = 3'd4,
        OP_RETURN  = 3'd5,
        OP_CHAR    = 3'd6
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  code;
        logic [7:0]  ch;
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  a3;
        logic [11:0] rd_cell;
    } cmd_t;

endpackage

[hw/rtl/text_screen_control_stream_top.sv]
// A set cursor or a cell attribute write first reduces the column by the row width, a row
// down each time; a cell attribute write then reads and rewrites the cell. A scroll reads
// and writes each moved cell, then blanks one row; a clear blanks lines*columns cells.
// The back executor takes a new request only once the last result is loaded for output.
// Reset: asynchronous, active low; the cell store is then swept once, (MAX_ROWS+1)*COLUMNS
// cells, while requests are held off.
module text_screen_control_stream_top
    import tscs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  stream_byte,
    input  logic [11:0] read_cell,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_data,
    output logic [11:0] cursor_cell,
    output logic [7:0]  write_attr,
    output logic [5:0]  screen_lines,
    output logic [15:0] chars_written
);

    cmd_t front_cmd, q_head;
    logic q_full, q_nonempty, q_pop, init_busy, accept;

    assign in_stall = q_full || init_busy;
    assign accept   = in_valid && !in_stall;

    tscs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .stream_byte (stream_byte),
        .read_cell   (read_cell),
        .cmd         (front_cmd)
    );

    tscs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    tscs_back #(
        .MAX_ROWS (MAX_ROWS),
        .COLUMNS  (COLUMNS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nonempty    (q_nonempty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_data     (cell_data),
        .cursor_cell   (cursor_cell),
        .write_attr    (write_attr),
        .screen_lines  (screen_lines),
        .chars_written (chars_written)
    );

endmodule

[hw/rtl/tscs_front.sv]
// Front decoder: accepts requests, collects argument bytes and classifies each request.
// Depends on tscs_pkg.
module tscs_front
    import tscs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        kind,
    input  logic [7:0]  stream_byte,
    input  logic [11:0] read_cell,
    output cmd_t        cmd
);

    logic [1:0] pend_reg, pend_next;
    logic [2:0] code_reg, code_next;
    logic [7:0] args_reg  [3];
    logic [7:0] args_next [3];

    always_comb
    begin
        pend_next = pend_reg;
        code_next = code_reg;
        args_next = args_reg;
        cmd.op    = OP_NOP;
        cmd.code  = code_reg;
        cmd.ch    = stream_byte;
        cmd.rd_cell = read_cell;
        if (kind)
        begin
            cmd.op = OP_READ;
        end
        else if (pend_reg != 2'd0)
        begin
            args_next[pend_reg - 2'd1] = stream_byte;
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1)
            begin
                cmd.op = OP_CMD;
            end
        end
        else
        begin
            priority if (stream_byte == {5'd0, CODE_SET_ATTR}
                         || stream_byte == {5'd0, CODE_SET_LINES})
            begin
                pend_next = 2'd1;
                code_next = stream_byte[2:0];
            end
            else if (stream_byte == {5'd0, CODE_SET_CURSOR}
                     || stream_byte == {5'd0, CODE_SCROLL}
                     || stream_byte == {5'd0, CODE_SET_REGION})
            begin
                pend_next = 2'd2;
                code_next = stream_byte[2:0];
            end
            else if (stream_byte == {5'd0, CODE_SET_CELL_ATTR})
            begin
                pend_next = 2'd3;
                code_next = stream_byte[2:0];
            end
            else if (stream_byte == {5'd0, CODE_CLEAR})
            begin
                cmd.op = OP_CLEAR;
            end
            else if (stream_byte == CHAR_LF)
            begin
                cmd.op = OP_NEWLINE;
            end
            else if (stream_byte == CHAR_CR)
            begin
                cmd.op = OP_RETURN;
            end
            else
            begin
                cmd.op = OP_CHAR;
            end
        end
        cmd.a1 = args_next[0];
        cmd.a2 = args_next[1];
        cmd.a3 = args_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 2'd0;
            code_reg    <= 3'd0;
            args_reg[0] <= 8'd0;
            args_reg[1] <= 8'd0;
            args_reg[2] <= 8'd0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            code_reg <= code_next;
            args_reg <= args_next;
        end
    end

endmodule

[hw/rtl/tscs_queue.sv]
// Short command queue between the front decoder and the back executor.
// Depends on tscs_pkg.
module tscs_queue
    import tscs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [NW-1:0] cnt_reg;

    assign full     = (cnt_reg == NW'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

endmodule

[hw/rtl/tscs_back.sv]
// Back executor: holds the cell store and screen state, carries out queued requests
// and registers one result per request. Depends on tscs_pkg.
module tscs_back
    import tscs_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int COLUMNS  = COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        init_busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_data,
    output logic [11:0] cursor_cell,
    output logic [7:0]  write_attr,
    output logic [5:0]  screen_lines,
    output logic [15:0] chars_written
);

    localparam int STORE = (MAX_ROWS + 1) * COLUMNS;
    localparam int AW    = $clog2(STORE + 1);
    localparam int MW    = $clog2(STORE);
    localparam int RW    = $clog2(MAX_ROWS + 2);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [6:0] {
        ST_FILL   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_NORM   = 7'b0000100,
        ST_RMW    = 7'b0001000,
        ST_SCR_RD = 7'b0010000,
        ST_SCR_WR = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0]    attr_reg, attr_next;
    logic [RW-1:0] lc_reg, lc_next;
    logic [RW-1:0] top_reg, top_next;
    logic [RW-1:0] bot_reg, bot_next;
    logic [RW-1:0] tr_reg, tr_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic          init_reg, init_next;
    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [AW-1:0] fill_end_reg, fill_end_next;
    logic [AW-1:0] scr_addr_reg, scr_addr_next;
    logic [AW-1:0] scr_end_reg, scr_end_next;
    logic [AW-1:0] rmw_addr_reg, rmw_addr_next;
    logic [8:0]    nr_reg, nr_next;
    logic [7:0]    nc_reg, nc_next;
    cmd_t          cmd_reg, cmd_next;
    logic          hit_reg, hit_next;

    logic          out_valid_reg;
    logic [15:0]   data_out_reg;
    logic [11:0]   cursor_out_reg;
    logic [7:0]    attr_out_reg;
    logic [5:0]    lines_out_reg;
    logic [15:0]   cnt_out_reg;
    logic          out_free, out_load;

    logic [15:0]   mem [STORE];
    logic [15:0]   rdata_reg;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    logic          launch;
    logic [RW-1:0] sc_top, sc_bot;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(r) * AW'(COLUMNS) + AW'(c);
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign init_busy = init_reg;

    always_comb
    begin
        logic [RW-1:0] nr;
        logic [CW-1:0] nc;
        logic [8:0]    band_end;

        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = attr_reg;
        lc_next        = lc_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        tr_next        = tr_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        scr_addr_next  = scr_addr_reg;
        scr_end_next   = scr_end_reg;
        rmw_addr_next  = rmw_addr_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        cmd_next       = cmd_reg;
        hit_next       = hit_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = fill_addr_reg;
        raddr          = fill_addr_reg;
        wdata          = {attr_reg, BLANK_CHAR};
        launch         = 1'b0;
        sc_top         = top_reg;
        sc_bot         = bot_reg;
        nr             = row_reg;
        nc             = col_reg;
        band_end       = 9'(cmd_reg.a2) + 9'(cmd_reg.a1);

        unique case (state_reg)
            ST_FILL:
            begin
                if (fill_addr_reg != fill_end_reg)
                begin
                    we             = 1'b1;
                    fill_addr_next = fill_addr_reg + AW'(1);
                end
                else
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                    init_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                    band_end   = 9'(q_head.a2) + 9'(q_head.a1);
                    unique case (q_head.op)
                        OP_READ:
                        begin
                            if (32'(q_head.rd_cell) < 32'(STORE))
                            begin
                                hit_next = 1'b1;
                                re       = 1'b1;
                                raddr    = AW'(q_head.rd_cell);
                            end
                        end
                        OP_CMD:
                        begin
                            unique case (q_head.code)
                                CODE_SET_ATTR:
                                begin
                                    attr_next = (q_head.a1 != 8'd0) ? q_head.a1 : SAFE_ATTR;
                                end
                                CODE_SET_CURSOR:
                                begin
                                    nr_next    = 9'(q_head.a1);
                                    nc_next    = q_head.a2;
                                    state_next = ST_NORM;
                                end
                                CODE_SET_CELL_ATTR:
                                begin
                                    nr_next    = 9'(q_head.a2);
                                    nc_next    = q_head.a3;
                                    state_next = ST_NORM;
                                end
                                CODE_SET_LINES:
                                begin
                                    if (q_head.a1 != 8'd0 && 32'(q_head.a1) <= MAX_ROWS)
                                    begin
                                        lc_next = RW'(q_head.a1);
                                    end
                                end
                                CODE_SCROLL:
                                begin
                                    if (band_end <= 9'(lc_reg) && q_head.a1 != 8'd0)
                                    begin
                                        launch = 1'b1;
                                        sc_top = RW'(q_head.a2);
                                        sc_bot = RW'(band_end);
                                    end
                                end
                                CODE_SET_REGION:
                                begin
                                    if (9'(q_head.a1) <= 9'(lc_reg)
                                        && 9'(q_head.a2) <= 9'(lc_reg)
                                        && q_head.a1 >= q_head.a2)
                                    begin
                                        top_next = RW'(q_head.a2);
                                        bot_next = RW'(q_head.a1);
                                        tr_next  = RW'(q_head.a1) + RW'(1);
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        OP_CLEAR:
                        begin
                            fill_addr_next = '0;
                            fill_end_next  = cell_addr(lc_reg, CW'(0));
                            state_next     = ST_FILL;
                        end
                        OP_NEWLINE:
                        begin
                            nr = row_reg + RW'(1);
                            nc = CW'(0);
                            if (nr == tr_reg)
                            begin
                                launch = 1'b1;
                                nr     = row_reg;
                            end
                            if (nr >= lc_reg)
                            begin
                                nr = lc_reg - RW'(1);
                            end
                            row_next = nr;
                            col_next = nc;
                            cnt_next = cnt_reg + 16'd1;
                        end
                        OP_RETURN:
                        begin
                            if (row_reg != '0 || col_reg != '0)
                            begin
                                if (col_reg == '0)
                                begin
                                    row_next = row_reg - RW'(1);
                                end
                                else
                                begin
                                    // blank the rest of the row
                                    fill_addr_next = cell_addr(row_reg, col_reg);
                                    fill_end_next  = cell_addr(row_reg, CW'(0))
                                                     + AW'(COLUMNS);
                                    state_next     = ST_FILL;
                                end
                                col_next = CW'(COLUMNS - 1);
                            end
                        end
                        OP_CHAR:
                        begin
                            we    = 1'b1;
                            waddr = cell_addr(row_reg, col_reg);
                            wdata = {attr_reg, q_head.ch};
                            if (row_reg < lc_reg)
                            begin
                                if (col_reg == CW'(COLUMNS - 1))
                                begin
                                    nr = row_reg + RW'(1);
                                    nc = CW'(0);
                                end
                                else
                                begin
                                    nc = col_reg + CW'(1);
                                end
                            end
                            if (nc == CW'(0) && nr == tr_reg)
                            begin
                                launch = 1'b1;
                                nr     = nr - RW'(1);
                            end
                            if (nr >= lc_reg)
                            begin
                                nr = lc_reg - RW'(1);
                                nc = CW'(COLUMNS - 1);
                            end
                            row_next = nr;
                            col_next = nc;
                            cnt_next = cnt_reg + 16'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NORM:
            begin
                if (nc_reg >= 8'(COLUMNS))
                begin
                    nc_next = nc_reg - 8'(COLUMNS);
                    nr_next = nr_reg + 9'd1;
                end
                else if (nr_reg < 9'(lc_reg))
                begin
                    if (cmd_reg.code == CODE_SET_CURSOR)
                    begin
                        row_next   = RW'(nr_reg);
                        col_next   = CW'(nc_reg);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        re            = 1'b1;
                        raddr         = cell_addr(RW'(nr_reg), CW'(nc_reg));
                        rmw_addr_next = raddr;
                        state_next    = ST_RMW;
                    end
                end
                else
                begin
                    if (cmd_reg.code == CODE_SET_CURSOR)
                    begin
                        row_next = '0;
                        col_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RMW:
            begin
                we         = 1'b1;
                waddr      = rmw_addr_reg;
                wdata      = {cmd_reg.a1, rdata_reg[7:0]};
                state_next = ST_DONE;
            end
            ST_SCR_RD:
            begin
                re         = 1'b1;
                raddr      = scr_addr_reg + AW'(COLUMNS);
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                we            = 1'b1;
                waddr         = scr_addr_reg;
                wdata         = rdata_reg;
                scr_addr_next = scr_addr_reg + AW'(1);
                if (scr_addr_next == scr_end_reg)
                begin
                    fill_addr_next = scr_end_reg;
                    fill_end_next  = scr_end_reg + AW'(COLUMNS);
                    state_next     = ST_FILL;
                end
                else
                begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move the band up one row, then blank its bottom row
        if (launch)
        begin
            scr_addr_next = cell_addr(sc_top, CW'(0));
            scr_end_next  = cell_addr(sc_bot, CW'(0));
            if (sc_bot > sc_top)
            begin
                state_next = ST_SCR_RD;
            end
            else
            begin
                fill_addr_next = cell_addr(sc_bot, CW'(0));
                fill_end_next  = cell_addr(sc_bot, CW'(0)) + AW'(COLUMNS);
                state_next     = ST_FILL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr[MW-1:0]] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr[MW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= RESET_ATTR;
            lc_reg        <= RW'(MAX_ROWS);
            top_reg       <= '0;
            bot_reg       <= RW'(MAX_ROWS);
            tr_reg        <= RW'(MAX_ROWS);
            cnt_reg       <= '0;
            init_reg      <= 1'b1;
            fill_addr_reg <= '0;
            fill_end_reg  <= AW'(STORE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            attr_reg      <= attr_next;
            lc_reg        <= lc_next;
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            tr_reg        <= tr_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scr_addr_reg <= scr_addr_next;
        scr_end_reg  <= scr_end_next;
        rmw_addr_reg <= rmw_addr_next;
        nr_reg       <= nr_next;
        nc_reg       <= nc_next;
        cmd_reg      <= cmd_next;
        hit_reg      <= hit_next;
        if (out_load)
        begin
            data_out_reg   <= (cmd_reg.op == OP_READ && hit_reg) ? rdata_reg : 16'd0;
            cursor_out_reg <= 12'(cell_addr(row_reg, col_reg));
            attr_out_reg   <= attr_reg;
            lines_out_reg  <= 6'(lc_reg);
            cnt_out_reg    <= cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_data     = data_out_reg;
    assign cursor_cell   = cursor_out_reg;
    assign write_attr    = attr_out_reg;
    assign screen_lines  = lines_out_reg;
    assign chars_written = cnt_out_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for text_screen_control_stream_top.
// Runs a directed table, then random byte streams and cell reads, against a local screen model.
// Depends on tscs_pkg and the top level RTL.
`timescale 1ns / 100ps

module tb_top;
    import tscs_pkg::*;

    localparam int ROWS        = MAX_ROWS_DEF;
    localparam int COLS        = COLUMNS_DEF;
    localparam int STORE       = (ROWS + 1) * COLS;
    localparam int RAND_ITEMS  = 1150;
    localparam int CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [11:0] cursor_cell;
        logic [7:0]  write_attr;
        logic [5:0]  screen_lines;
        logic [15:0] chars_written;
    } screen_result_t;

    typedef struct {
        logic           k;
        logic [7:0]     b;
        logic [11:0]    c;
        bit             typed;
        screen_result_t r;
    } request_t;

    typedef enum int {
        EP_TEXT, EP_NEWLINE, EP_RETURN, EP_READ, EP_ATTR, EP_CURSOR, EP_CELL_ATTR,
        EP_LINES, EP_SCROLL, EP_REGION, EP_CLEAR, EP_NOISE
    } episode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  stream_byte;
    logic [11:0] read_cell;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] cell_data;
    logic [11:0] cursor_cell;
    logic [7:0]  write_attr;
    logic [5:0]  screen_lines;
    logic [15:0] chars_written;

    text_screen_control_stream_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .stream_byte   (stream_byte),
        .read_cell     (read_cell),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_data     (cell_data),
        .cursor_cell   (cursor_cell),
        .write_attr    (write_attr),
        .screen_lines  (screen_lines),
        .chars_written (chars_written)
    );

    // Screen model state
    logic [15:0] scr [0:STORE-1];
    int          cur;
    int          attr;
    int          lines;
    int          rtop;
    int          rbot;
    int          trig;
    int          pend;
    logic [2:0]  pcode;
    logic [7:0]  args [0:2];
    logic [15:0] nchars;

    screen_result_t expected_q[$];
    int errors;
    int n_sent;
    int n_reads;
    int n_results;
    int n_cmds;
    int burst_left;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] blank();
        return {attr[7:0], BLANK_CHAR};
    endfunction

    function automatic void put(int idx, logic [15:0] v);
        if (idx < STORE)
            scr[idx] = v;
    endfunction

    function automatic void scroll_rows(int top, int bot);
        if (bot > top)
            for (int i = top * COLS; i < bot * COLS; i++)
                if (i + COLS < STORE)
                    scr[i] = scr[i + COLS];
        for (int i = 0; i < COLS; i++)
            put(bot * COLS + i, blank());
    endfunction

    function automatic void run_pending();
        int a1;
        int a2;
        int a3;
        int pos;
        a1 = args[0];
        a2 = args[1];
        a3 = args[2];
        case (pcode)
            CODE_SET_ATTR:
                attr = (a1 != 0) ? a1 : SAFE_ATTR;
            CODE_SET_CURSOR:
            begin
                pos = a2 + a1 * COLS;
                cur = (pos < lines * COLS) ? pos : 0;
            end
            CODE_SET_CELL_ATTR:
            begin
                pos = a3 + a2 * COLS;
                if (pos < lines * COLS && pos < STORE)
                    scr[pos] = {a1[7:0], scr[pos][7:0]};
            end
            CODE_SET_LINES:
                if (a1 != 0 && a1 <= ROWS)
                    lines = a1;
            CODE_SCROLL:
                if (a2 + a1 <= lines && a1 != 0)
                    scroll_rows(a2, a2 + a1);
            CODE_SET_REGION:
                if (a1 <= lines && a2 <= lines && a1 >= a2)
                begin
                    rtop = a2;
                    rbot = a1;
                    trig = (a1 + 1) * COLS;
                end
            default: ;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int vis;
        vis = lines * COLS;
        if (b == {5'd0, CODE_SET_ATTR} || b == {5'd0, CODE_SET_LINES})
        begin
            pend = 1;
            pcode = b[2:0];
        end
        else if (b == {5'd0, CODE_SET_CURSOR} || b == {5'd0, CODE_SCROLL} ||
                 b == {5'd0, CODE_SET_REGION})
        begin
            pend = 2;
            pcode = b[2:0];
        end
        else if (b == {5'd0, CODE_SET_CELL_ATTR})
        begin
            pend = 3;
            pcode = b[2:0];
        end
        else if (b == {5'd0, CODE_CLEAR})
        begin
            for (int i = 0; i < vis; i++)
                put(i, blank());
        end
        else if (b == CHAR_LF)
        begin
            cur = (cur / COLS) * COLS + COLS;
            if (cur == trig)
            begin
                scroll_rows(rtop, rbot);
                cur -= COLS;
            end
            if (cur >= vis)
                cur = vis - COLS;
            nchars++;
        end
        else if (b == CHAR_CR)
        begin
            if (cur != 0)
            begin
                while (cur % COLS != 0)
                begin
                    put(cur, blank());
                    cur++;
                end
                cur--;
            end
        end
        else
        begin
            put(cur, {attr[7:0], b});
            if (cur < vis)
                cur++;
            if (cur == trig)
            begin
                scroll_rows(rtop, rbot);
                cur -= COLS;
            end
            if (cur >= vis)
                cur = vis - 1;
            nchars++;
        end
    endfunction

    function automatic screen_result_t predict_screen(logic k, logic [7:0] b, logic [11:0] c);
        screen_result_t r;
        r.cell_data = 16'd0;
        if (k)
        begin
            if (c < STORE)
                r.cell_data = scr[c];
        end
        else if (pend != 0)
        begin
            args[pend - 1] = b;
            pend--;
            if (pend == 0)
                run_pending();
        end
        else
            take_byte(b);
        r.cursor_cell   = cur[11:0];
        r.write_attr    = attr[7:0];
        r.screen_lines  = lines[5:0];
        r.chars_written = nchars;
        return r;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Drive one request and hold it until accepted; predict on acceptance.
    task automatic send(request_t rq);
        screen_result_t r;
        kind        <= rq.k;
        stream_byte <= rq.b;
        read_cell   <= rq.c;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_screen(rq.k, rq.b, rq.c);
        expected_q.push_back(rq.typed ? rq.r : r);
        n_sent++;
        if (rq.k)
            n_reads++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    endtask

    function automatic request_t mk(logic k, logic [7:0] b, logic [11:0] c);
        request_t rq;
        rq.k = k;
        rq.b = b;
        rq.c = c;
        rq.typed = 1'b0;
        rq.r = '0;
        return rq;
    endfunction

    function automatic request_t byte_rq(int b);
        return mk(1'b0, b[7:0], 12'($urandom));
    endfunction

    function automatic request_t typed_rq(logic k, logic [7:0] b, logic [11:0] c,
                                          logic [15:0] d, logic [11:0] cc, logic [15:0] ch);
        request_t rq;
        rq = mk(k, b, c);
        rq.typed = 1'b1;
        rq.r = '{d, cc, RESET_ATTR, 6'(ROWS), ch};
        return rq;
    endfunction

    // Receiver: check results and stall in changing modes
    always @(posedge clk)
    begin : receive
        screen_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual cursor %0h", $time,
                         cursor_cell);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_results++;
                check_field("cell_data", e.cell_data, cell_data);
                check_field("cursor_cell", e.cursor_cell, cursor_cell);
                check_field("write_attr", e.write_attr, write_attr);
                check_field("screen_lines", e.screen_lines, screen_lines);
                check_field("chars_written", e.chars_written, chars_written);
            end
        end
        case ((cycles / 97) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= (cycles % 5 < 2);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : main
        request_t   table_q[$];
        request_t   ep[$];
        episode_t   e;
        int         lim;
        int         w;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        stream_byte = 8'd0;
        read_cell   = 12'd0;
        out_stall   = 1'b0;
        cycles      = 0;
        errors      = 0;
        n_sent      = 0;
        n_reads     = 0;
        n_results   = 0;
        n_cmds      = 0;
        burst_left  = 5;
        for (int i = 0; i < STORE; i++)
            scr[i] = {RESET_ATTR, BLANK_CHAR};
        cur = 0;
        attr = RESET_ATTR;
        lines = ROWS;
        rtop = 0;
        rbot = ROWS;
        trig = ROWS * COLS;
        pend = 0;
        pcode = 3'd0;
        args[0] = 8'd0;
        args[1] = 8'd0;
        args[2] = 8'd0;
        nchars = 16'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset state, read range ends, return at cell zero
        table_q.push_back(typed_rq(1'b1, 8'hFF, 12'd0, {RESET_ATTR, BLANK_CHAR}, 12'd0, 16'd0));
        table_q.push_back(typed_rq(1'b1, 8'h00, 12'hFFF, 16'd0, 12'd0, 16'd0));
        table_q.push_back(typed_rq(1'b1, 8'h00, 12'(STORE - 1), {RESET_ATTR, BLANK_CHAR},
                                   12'd0, 16'd0));
        table_q.push_back(typed_rq(1'b0, CHAR_CR, 12'hFFF, 16'd0, 12'd0, 16'd0));
        table_q.push_back(byte_rq("A"));
        table_q.push_back(byte_rq(0));
        table_q.push_back(byte_rq(255));
        table_q.push_back(byte_rq(CHAR_CR));
        table_q.push_back(byte_rq(CHAR_LF));
        table_q.push_back(byte_rq(CODE_SET_ATTR));
        table_q.push_back(byte_rq(0));
        table_q.push_back(byte_rq(CODE_SET_CURSOR));
        table_q.push_back(byte_rq(COLS - 1));
        table_q.push_back(mk(1'b1, 8'h00, 12'd1));
        table_q.push_back(byte_rq(ROWS - 1));
        table_q.push_back(byte_rq("Z"));
        table_q.push_back(byte_rq(CODE_SET_CELL_ATTR));
        table_q.push_back(byte_rq(CODE_SET_CURSOR));
        table_q.push_back(byte_rq(CODE_SET_CELL_ATTR));
        table_q.push_back(byte_rq(CODE_CLEAR));
        table_q.push_back(byte_rq(CODE_SET_LINES));
        table_q.push_back(byte_rq(0));
        table_q.push_back(byte_rq(CODE_SET_LINES));
        table_q.push_back(byte_rq(3));
        table_q.push_back(byte_rq("q"));
        table_q.push_back(byte_rq(CODE_SET_REGION));
        table_q.push_back(byte_rq(0));
        table_q.push_back(byte_rq(1));
        table_q.push_back(byte_rq(CODE_SCROLL));
        table_q.push_back(byte_rq(0));
        table_q.push_back(byte_rq(2));
        table_q.push_back(byte_rq(CODE_CLEAR));
        table_q.push_back(byte_rq(CHAR_LF));
        table_q.push_back(byte_rq(CHAR_LF));
        table_q.push_back(mk(1'b1, 8'h5A, 12'd3));
        foreach (table_q[i])
            send(table_q[i]);

        // Random part: mostly well-formed command sequences with random content
        while (n_sent < RAND_ITEMS)
        begin
            ep.delete();
            w = $urandom_range(0, 99);
            if (w < 30)      e = EP_TEXT;
            else if (w < 40) e = EP_NEWLINE;
            else if (w < 45) e = EP_RETURN;
            else if (w < 62) e = EP_READ;
            else if (w < 67) e = EP_ATTR;
            else if (w < 73) e = EP_CURSOR;
            else if (w < 78) e = EP_CELL_ATTR;
            else if (w < 83) e = EP_LINES;
            else if (w < 88) e = EP_SCROLL;
            else if (w < 93) e = EP_REGION;
            else if (w < 95) e = EP_CLEAR;
            else             e = EP_NOISE;
            case (e)
                EP_TEXT:
                    repeat ($urandom_range(1, 8))
                        ep.push_back(byte_rq($urandom_range(0, 7) == 0 ?
                                             $urandom_range(0, 255) : $urandom_range(32, 126)));
                EP_NEWLINE: ep.push_back(byte_rq(CHAR_LF));
                EP_RETURN:  ep.push_back(byte_rq(CHAR_CR));
                EP_READ:
                begin
                    lim = (lines + 1) * COLS - 1;
                    ep.push_back(mk(1'b1, 8'($urandom), $urandom_range(0, 1) ?
                                    12'($urandom_range(0, lim)) : 12'($urandom)));
                end
                EP_ATTR:
                begin
                    ep.push_back(byte_rq(CODE_SET_ATTR));
                    ep.push_back(byte_rq($urandom_range(0, 5) == 0 ? 0 : $urandom_range(0, 255)));
                end
                EP_CURSOR:
                begin
                    ep.push_back(byte_rq(CODE_SET_CURSOR));
                    ep.push_back(byte_rq($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 255) : $urandom_range(0, COLS - 1)));
                    ep.push_back(byte_rq($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 255) : $urandom_range(0, lines)));
                end
                EP_CELL_ATTR:
                begin
                    ep.push_back(byte_rq(CODE_SET_CELL_ATTR));
                    ep.push_back(byte_rq($urandom_range(0, COLS + 4)));
                    ep.push_back(mk(1'b1, 8'($urandom), 12'($urandom_range(0, 4 * COLS))));
                    ep.push_back(byte_rq($urandom_range(0, lines)));
                    ep.push_back(byte_rq($urandom_range(0, 255)));
                end
                EP_LINES:
                begin
                    ep.push_back(byte_rq(CODE_SET_LINES));
                    w = $urandom_range(0, 9);
                    ep.push_back(byte_rq(w == 0 ? $urandom_range(0, 255) :
                                         w == 1 ? ROWS : $urandom_range(1, 8)));
                end
                EP_SCROLL:
                begin
                    ep.push_back(byte_rq(CODE_SCROLL));
                    ep.push_back(byte_rq($urandom_range(0, lines)));
                    ep.push_back(byte_rq($urandom_range(0, 4)));
                end
                EP_REGION:
                begin
                    ep.push_back(byte_rq(CODE_SET_REGION));
                    w = $urandom_range(0, lines);
                    ep.push_back(byte_rq(w));
                    ep.push_back(byte_rq($urandom_range(0, 4) == 0 ?
                                         $urandom_range(0, 255) : $urandom_range(w, lines)));
                end
                EP_CLEAR:   ep.push_back(byte_rq(CODE_CLEAR));
                default:
                    // Broken sequences: a command cut by stray bytes or reads
                    repeat ($urandom_range(1, 3))
                        ep.push_back(mk(1'($urandom), 8'($urandom_range(0, 255)),
                                        12'($urandom)));
            endcase
            if (e != EP_READ && e != EP_TEXT && e != EP_NEWLINE && e != EP_RETURN)
                n_cmds++;
            foreach (ep[i])
                send(ep[i]);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("sent %0d requests (%0d cell reads, %0d command or noise sequences),",
                 n_sent, n_reads, n_cmds);
        $display("checked %0d results, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
